FILE: sv/acbm_pkg.sv
// ----------------------------------------------------------------------------
// acbm_pkg
// Shared types and constants for the byte-wide multi-pattern matcher.
// ----------------------------------------------------------------------------
package acbm_pkg;

	localparam int NODE_COUNT  = 1024;
	localparam int NODE_W      = 10;
	localparam int USED_W      = NODE_W + 1;
	localparam int MAX_KEY_LEN = 32;
	localparam int LEN_W       = 6;
	localparam int RESULT_CAP  = 32;
	localparam int CNT_W       = 6;
	localparam int CHILD_AW    = NODE_W + 8;
	localparam int CHILD_DEPTH = NODE_COUNT * 256;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_LINK   = 2'd1,
		FUNC_SCAN   = 2'd2,
		FUNC_START  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_INS_OK   = 2'd0,
		KIND_INS_FAIL = 2'd1,
		KIND_MATCH    = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef struct packed {
		func_t              func;
		logic [7:0]         data_byte;
		logic               key_end;
		logic [7:0]         key_type;
		logic [NODE_W-1:0]  node;
		logic [NODE_W-1:0]  target_node;
		logic [31:0]        start_pos;
	} req_t;

	typedef struct packed {
		kind_t              kind;
		logic [NODE_W-1:0]  node_index;
		logic [31:0]        match_start;
		logic [LEN_W-1:0]   match_len;
		logic [7:0]         match_kind;
		logic               last;
	} rsp_t;

	// Classified command handed from the front end to the sequencer.
	typedef struct packed {
		func_t              op;
		logic [7:0]         data_byte;
		logic               key_end;
		logic [7:0]         key_type;
		logic [NODE_W-1:0]  node;
		logic [NODE_W-1:0]  target_node;
		logic [31:0]        start_pos;
		logic               link_ok;
		logic               zero_byte;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic cmd_ready;
	} stat_t;

endpackage

FILE: sv/aho_corasick_byte_matcher_core.sv
// ----------------------------------------------------------------------------
// aho_corasick_byte_matcher_core
// Byte-wide multi-pattern matcher with a trie built by insert transactions.
// ----------------------------------------------------------------------------
// Usage: requests enter on req_valid/req_ready with a req_t payload; results
// leave on rsp_valid/rsp_ready with an rsp_t payload. A two-entry queue sits
// between the request port and the sequencer, so requests are taken while the
// sequencer works or while a result waits in the output register.
// An insert gives one result. A load-link or start transaction gives none. A
// scan byte follows failure links, then walks the match chain; its matches
// leave in order, the final one flagged last. The trie memories inside the
// sequencer are read through registers.
// After reset the sequencer clears the failure-link and node-type memories,
// one entry a cycle, with req_ready low. The child table needs no clearing.
// When the receiver stalls, the sequencer waits with the next result pending
// and the request queue fills, then req_ready drops.
// ----------------------------------------------------------------------------
module aho_corasick_byte_matcher_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  acbm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output acbm_pkg::rsp_t rsp
);
	import acbm_pkg::*;

	logic  cmd_valid;
	cmd_t  cmd;
	stat_t stat;

	acbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.stat      (stat),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	acbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

FILE: sv/acbm_front.sv
// ----------------------------------------------------------------------------
// acbm_front
// Accepts request transactions, classifies them and holds them in a
// two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module acbm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  acbm_pkg::req_t  req,
	input  acbm_pkg::stat_t stat,
	output logic            cmd_valid,
	output acbm_pkg::cmd_t  cmd
);
	import acbm_pkg::*;

	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.op          = req.func;
		cls.data_byte   = req.data_byte;
		cls.key_end     = req.key_end;
		cls.key_type    = req.key_type;
		cls.node        = req.node;
		cls.target_node = req.target_node;
		cls.start_pos   = req.start_pos;
		cls.link_ok     = ({1'b0, req.node} < USED_W'(NODE_COUNT)) &&
			({1'b0, req.target_node} < USED_W'(NODE_COUNT));
		cls.zero_byte   = (req.data_byte == 8'd0);
	end

	assign req_ready = (count_q != 2'd2) && !stat.clearing;
	assign push      = req_valid && req_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = q_q[rd_ptr_q];
	assign pop       = cmd_valid && stat.cmd_ready;

	always_ff @(posedge clk) begin
		if (push) q_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule

FILE: sv/acbm_back.sv
// ----------------------------------------------------------------------------
// acbm_back
// Sequencer that owns the trie memories: builds keys, loads failure links
// and walks the failure and match chains for each text byte.
// ----------------------------------------------------------------------------
module acbm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  acbm_pkg::cmd_t  cmd,
	output acbm_pkg::stat_t stat,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output acbm_pkg::rsp_t  rsp
);
	import acbm_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_INS_A, S_INS_B, S_INS_C,
		S_SC_A, S_SC_B, S_SC_C, S_MT_A, S_MT_B, S_FLUSH
	} state_t;

	localparam int TL_W = 8 + LEN_W;

	// Child edges are checked against the parent record of the child node, so
	// stale contents never need clearing: a node is allocated for one edge only.
	logic [NODE_W-1:0]   child_mem [CHILD_DEPTH];
	logic [CHILD_AW-1:0] par_mem   [NODE_COUNT];
	logic [NODE_W-1:0]   fail_mem  [NODE_COUNT];
	logic [TL_W-1:0]     tl_mem    [NODE_COUNT];

	logic [NODE_W-1:0]   child_rd_q;
	logic [CHILD_AW-1:0] par_rd_q;
	logic [NODE_W-1:0]   fail_rd_q;
	logic [TL_W-1:0]     tl_rd_q;

	state_t              state_q;
	logic [NODE_W-1:0]   look_q;
	logic [7:0]          byte_q;
	logic                end_q;
	logic [7:0]          mtype_q;
	logic [NODE_W-1:0]   cur_q;
	logic [LEN_W-1:0]    depth_q;
	logic [USED_W-1:0]   used_q;
	logic [NODE_W-1:0]   scan_q;
	logic [31:0]         pos_q;
	logic                ended_q;
	logic [LEN_W-1:0]    steps_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                pend_q;
	logic [31:0]         pend_start_q;
	logic [LEN_W-1:0]    pend_len_q;
	logic [7:0]          pend_kind_q;
	logic [NODE_W-1:0]   clr_q;
	rsp_t                out_q;
	logic                out_valid_q;

	logic                out_free;
	logic                out_load;
	rsp_t                ins_rsp;
	rsp_t                mt_rsp;
	logic                hit;
	logic                too_long;
	logic                full;
	logic                ins_ok;
	logic                ins_alloc;
	logic [NODE_W-1:0]   ins_nxt;
	logic [LEN_W-1:0]    depth_inc;
	logic                is_match;
	logic [LEN_W-1:0]    steps_inc;
	logic [CNT_W-1:0]    cnt_next;
	logic                pop;

	logic                child_we;
	logic                par_we;
	logic                fail_we;
	logic [NODE_W-1:0]   fail_wa;
	logic [NODE_W-1:0]   fail_wd;
	logic                tl_we;
	logic [NODE_W-1:0]   tl_wa;
	logic [TL_W-1:0]     tl_wd;

	assign out_free  = !out_valid_q || rsp_ready;
	assign hit       = (child_rd_q != '0) && ({1'b0, child_rd_q} < used_q) &&
		(par_rd_q == {look_q, byte_q});
	assign too_long  = depth_q >= LEN_W'(MAX_KEY_LEN);
	assign full      = used_q >= USED_W'(NODE_COUNT);
	assign ins_ok    = !too_long && (hit || !full);
	assign ins_alloc = !too_long && !hit && !full;
	assign ins_nxt   = hit ? child_rd_q : used_q[NODE_W-1:0];
	assign depth_inc = depth_q + LEN_W'(1);
	assign is_match  = (tl_rd_q[TL_W-1:LEN_W] != 8'd0);
	assign steps_inc = steps_q + LEN_W'(1);
	assign cnt_next  = cnt_q + CNT_W'(is_match);
	assign pop       = cmd_valid && (state_q == S_IDLE);

	// A result register load happens in exactly one of these three places.
	assign out_load = out_free && (
		(state_q == S_INS_C) ||
		(state_q == S_MT_B && is_match && pend_q) ||
		(state_q == S_FLUSH && pend_q));

	assign stat.clearing  = (state_q == S_CLEAR);
	assign stat.cmd_ready = (state_q == S_IDLE);
	assign rsp_valid      = out_valid_q;
	assign rsp            = out_q;

	always_comb begin
		ins_rsp             = '0;
		ins_rsp.kind        = ins_ok ? KIND_INS_OK : KIND_INS_FAIL;
		ins_rsp.node_index  = ins_ok ? ins_nxt : '0;
		ins_rsp.last        = 1'b1;
		mt_rsp              = '0;
		mt_rsp.kind         = KIND_MATCH;
		mt_rsp.match_start  = pend_start_q;
		mt_rsp.match_len    = pend_len_q;
		mt_rsp.match_kind   = pend_kind_q;
		mt_rsp.last         = (state_q == S_FLUSH);
	end

	always_comb begin
		child_we = 1'b0;
		par_we   = 1'b0;
		fail_we  = 1'b0;
		fail_wa  = used_q[NODE_W-1:0];
		fail_wd  = '0;
		tl_we    = 1'b0;
		tl_wa    = ins_nxt;
		tl_wd    = end_q ? {mtype_q, depth_inc} : '0;
		unique case (state_q)
			S_CLEAR: begin
				fail_we = 1'b1;
				fail_wa = clr_q;
				tl_we   = 1'b1;
				tl_wa   = clr_q;
				tl_wd   = '0;
			end
			S_IDLE: begin
				fail_we = pop && (cmd.op == FUNC_LINK) && cmd.link_ok;
				fail_wa = cmd.node;
				fail_wd = cmd.target_node;
			end
			S_INS_C: begin
				if (out_free) begin
					child_we = ins_alloc;
					par_we   = ins_alloc;
					fail_we  = ins_alloc;
					tl_we    = ins_ok && (ins_alloc || end_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		child_rd_q <= child_mem[{look_q, byte_q}];
		par_rd_q   <= par_mem[child_rd_q];
		fail_rd_q  <= fail_mem[look_q];
		tl_rd_q    <= tl_mem[look_q];
		if (child_we) child_mem[{look_q, byte_q}] <= used_q[NODE_W-1:0];
		if (par_we) par_mem[used_q[NODE_W-1:0]] <= {look_q, byte_q};
		if (fail_we) fail_mem[fail_wa] <= fail_wd;
		if (tl_we) tl_mem[tl_wa] <= tl_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			look_q       <= '0;
			byte_q       <= '0;
			end_q        <= 1'b0;
			mtype_q      <= '0;
			cur_q        <= '0;
			depth_q      <= '0;
			used_q       <= USED_W'(1);
			scan_q       <= '0;
			pos_q        <= '0;
			ended_q      <= 1'b0;
			steps_q      <= '0;
			cnt_q        <= '0;
			pend_q       <= 1'b0;
			pend_start_q <= '0;
			pend_len_q   <= '0;
			pend_kind_q  <= '0;
			clr_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !rsp_ready);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODE_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (pop) begin
						byte_q  <= cmd.data_byte;
						end_q   <= cmd.key_end;
						mtype_q <= cmd.key_type;
						unique case (cmd.op)
							FUNC_INSERT: begin
								look_q  <= cur_q;
								state_q <= S_INS_A;
							end
							FUNC_LINK: ;
							FUNC_SCAN: begin
								if (!ended_q) begin
									if (cmd.zero_byte) begin
										ended_q <= 1'b1;
									end else begin
										pos_q   <= pos_q + 32'd1;
										look_q  <= scan_q;
										steps_q <= '0;
										state_q <= S_SC_A;
									end
								end
							end
							FUNC_START: begin
								scan_q  <= '0;
								pos_q   <= cmd.start_pos;
								ended_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_INS_A: state_q <= S_INS_B;
				S_INS_B: state_q <= S_INS_C;
				S_INS_C: begin
					if (out_free) begin
						out_q   <= ins_rsp;
						state_q <= S_IDLE;
						if (!ins_ok) begin
							cur_q   <= '0;
							depth_q <= '0;
						end else begin
							if (ins_alloc) used_q <= used_q + USED_W'(1);
							if (end_q) begin
								cur_q   <= '0;
								depth_q <= '0;
							end else begin
								cur_q   <= ins_nxt;
								depth_q <= depth_inc;
							end
						end
					end
				end
				S_SC_A: state_q <= S_SC_B;
				S_SC_B: state_q <= S_SC_C;
				S_SC_C: begin
					if (hit || look_q == '0) begin
						scan_q  <= hit ? child_rd_q : '0;
						look_q  <= hit ? child_rd_q : '0;
						steps_q <= '0;
						cnt_q   <= '0;
						state_q <= hit ? S_MT_A : S_FLUSH;
					end else if (steps_q >= LEN_W'(MAX_KEY_LEN)) begin
						look_q  <= '0;
						state_q <= S_SC_A;
					end else begin
						look_q  <= fail_rd_q;
						steps_q <= steps_inc;
						state_q <= S_SC_A;
					end
				end
				S_MT_A: state_q <= S_MT_B;
				S_MT_B: begin
					if (!(is_match && pend_q && !out_free)) begin
						if (is_match) begin
							if (pend_q) out_q <= mt_rsp;
							pend_q       <= 1'b1;
							pend_len_q   <= tl_rd_q[LEN_W-1:0];
							pend_kind_q  <= tl_rd_q[TL_W-1:LEN_W];
							pend_start_q <= pos_q - 32'(tl_rd_q[LEN_W-1:0]);
						end
						cnt_q   <= cnt_next;
						steps_q <= steps_inc;
						look_q  <= fail_rd_q;
						if (fail_rd_q == '0 || steps_inc >= LEN_W'(MAX_KEY_LEN) ||
							cnt_next >= CNT_W'(RESULT_CAP))
							state_q <= S_FLUSH;
						else
							state_q <= S_MT_A;
					end
				end
				S_FLUSH: begin
					if (!pend_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q   <= mt_rsp;
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q >= USED_W'(1) && used_q <= USED_W'(NODE_COUNT))
		else $error("node count out of range");

	a_pend_counted: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> cnt_q != '0) else $error("held match not counted");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !out_valid_q) else $error("result during clear");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= LEN_W'(MAX_KEY_LEN)) else $error("key depth out of range");

	a_insert_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != KIND_MATCH) |-> out_q.last)
		else $error("insert result without last");

endmodule
